[src/mqpub_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mqpub_pkg
// Types and codes shared by the MQTT publish handshake core.
// ----------------------------------------------------------------------------
package mqpub_pkg;

  // Event codes
  localparam logic [1:0] OP_PUBLISH = 2'd0;
  localparam logic [1:0] OP_ACK     = 2'd1;
  localparam logic [1:0] OP_TICK    = 2'd2;

  // Received acknowledge packet kinds
  localparam logic [1:0] ACK_PUBACK  = 2'd0;
  localparam logic [1:0] ACK_PUBREC  = 2'd1;
  localparam logic [1:0] ACK_PUBCOMP = 2'd2;

  // Result actions
  localparam logic [2:0] ACT_PUBLISH   = 3'd0;
  localparam logic [2:0] ACT_PUBREL    = 3'd1;
  localparam logic [2:0] ACT_DONE_OK   = 3'd2;
  localparam logic [2:0] ACT_DONE_FAIL = 3'd3;
  localparam logic [2:0] ACT_BUSY      = 3'd4;

  // Quality of service levels
  localparam logic [1:0] QOS_1 = 2'd1;
  localparam logic [1:0] QOS_2 = 2'd2;

  // Configuration register indexes
  localparam int unsigned   CFG_IDX_W        = 1;
  localparam logic [CFG_IDX_W-1:0] REG_REPLY_WAIT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_TRIES  = 1'b1;
  localparam int unsigned   CFG_DATA_W       = 16;

  // Reset values of the configuration registers
  localparam logic [15:0] DEF_REPLY_WAIT = 16'd100;
  localparam logic [3:0]  DEF_MAX_TRIES  = 4'd3;

  typedef enum logic [2:0] {
    ST_IDLE      = 3'b001,
    ST_WAIT_ACK  = 3'b010,
    ST_WAIT_COMP = 3'b100
  } state_t;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [1:0]  request_qos;
    logic        request_retain;
    logic [1:0]  ack_kind;
    logic [15:0] ack_message_id;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  action;
    logic [15:0] message_id;
    logic [1:0]  qos;
    logic        retain;
    logic        dup;
  } out_item_t;

  typedef struct packed {
    logic [15:0] reply_wait_ticks;
    logic [3:0]  max_tries;
  } cfg_t;

  typedef struct packed {
    logic        busy;
    logic [15:0] next_id;
  } status_t;

endpackage

[src/mqtt_publish_qos_handshake_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mqtt_publish_qos_handshake_core
// Sender side of the MQTT QoS 1 / QoS 2 publish handshake.
// ----------------------------------------------------------------------------
// The core takes one event per clock while the result side does not stall:
// a publish request, a received acknowledge packet or a one millisecond tick.
// Each accepted event lands in an input register, is evaluated against the
// handshake state once the result register can take its result, and its
// result (if any) is registered in the result register. The state update is
// a single pass of compares and increments.
// A held result blocks the engine but the input register still takes one
// more event. Configuration writes take effect at once and belong to idle
// periods.
// ----------------------------------------------------------------------------
module mqtt_publish_qos_handshake_core (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  mqpub_pkg::in_item_t                   in_data,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output mqpub_pkg::out_item_t                  out_data,
  input  logic                                 cfg_we,
  input  logic [mqpub_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [mqpub_pkg::CFG_DATA_W-1:0]     cfg_data
);

  mqpub_pkg::cfg_t      cfg;
  mqpub_pkg::in_item_t  stage_item;
  mqpub_pkg::out_item_t res_item;
  mqpub_pkg::status_t   status;
  logic                 stage_valid;
  logic                 advance;
  logic                 step;
  logic                 res_valid;

  // Configuration registers: reply timeout and attempt limit
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.reply_wait_ticks <= mqpub_pkg::DEF_REPLY_WAIT;
      cfg.max_tries        <= mqpub_pkg::DEF_MAX_TRIES;
    end else if (cfg_we) begin
      case (cfg_index)
        mqpub_pkg::REG_REPLY_WAIT: cfg.reply_wait_ticks <= cfg_data;
        mqpub_pkg::REG_MAX_TRIES:  cfg.max_tries        <= cfg_data[3:0];
        default: begin
        end
      endcase
    end
  end

  // Input register; stalls only when it is full and the result side is held
  mqpub_in_stage u_in_stage (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .advance     (advance),
    .stage_valid (stage_valid),
    .stage_item  (stage_item)
  );

  // Consume the held event whenever the result register can take its result
  assign step = stage_valid && advance;

  mqpub_engine u_engine (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .item      (stage_item),
    .cfg       (cfg),
    .res_valid (res_valid),
    .res_item  (res_item),
    .status    (status)
  );

  mqpub_out_stage u_out_stage (
    .clk       (clk),
    .rst       (rst),
    .load      (step),
    .res_valid (res_valid),
    .res_item  (res_item),
    .advance   (advance),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // Only a full input register may push back on the sender
  a_stall_needs_full : assert property (@(posedge clk) disable iff (rst)
    in_stall |-> stage_valid)
    else $error("input stalled with an empty input register");

  // The id counter never hands out zero
  a_next_id_nonzero : assert property (@(posedge clk) disable iff (rst)
    status.next_id != 16'd0)
    else $error("message id counter reached zero");

  // A busy rejection carries no message id
  a_busy_no_id : assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.action == mqpub_pkg::ACT_BUSY) |-> out_data.message_id == 16'd0)
    else $error("busy rejection carries a message id");

  // Ordering a PUBLISH or PUBREL leaves an exchange open
  a_send_keeps_busy : assert property (@(posedge clk) disable iff (rst)
    (step && res_valid && (res_item.action == mqpub_pkg::ACT_PUBLISH ||
                           res_item.action == mqpub_pkg::ACT_PUBREL)) |=> status.busy)
    else $error("send ordered but engine went idle");

endmodule

[src/mqpub_in_stage.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mqpub_in_stage
// Input register: holds one accepted event until the engine consumes it.
// ----------------------------------------------------------------------------
module mqpub_in_stage (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  mqpub_pkg::in_item_t in_data,
  input  logic               advance,
  output logic               stage_valid,
  output mqpub_pkg::in_item_t stage_item
);

  logic accept;

  assign in_stall = stage_valid && !advance;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (accept) begin
      stage_valid <= 1'b1;
    end else if (advance) begin
      stage_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      stage_item <= in_data;
    end
  end

endmodule

[src/mqpub_engine.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mqpub_engine
// Handshake state, id counter, retry count and reply timer; one event a step.
// ----------------------------------------------------------------------------
module mqpub_engine (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  mqpub_pkg::in_item_t  item,
  input  mqpub_pkg::cfg_t      cfg,
  output logic                res_valid,
  output mqpub_pkg::out_item_t res_item,
  output mqpub_pkg::status_t   status
);

  mqpub_pkg::state_t state, state_next;
  logic [1:0]  cur_qos, cur_qos_next;
  logic        cur_retain, cur_retain_next;
  logic [15:0] cur_id, cur_id_next;
  logic [15:0] next_id, next_id_next;
  logic [3:0]  tries, tries_next;
  logic [15:0] wait_timer, wait_timer_next;

  logic        busy;
  logic [1:0]  rq;
  logic [3:0]  tries_inc;

  assign busy      = (state != mqpub_pkg::ST_IDLE);
  assign rq        = (item.request_qos >= mqpub_pkg::QOS_2) ? mqpub_pkg::QOS_2
                                                            : mqpub_pkg::QOS_1;
  assign tries_inc = tries + 4'd1;

  assign status.busy    = busy;
  assign status.next_id = next_id;

  always_comb begin
    state_next      = state;
    cur_qos_next    = cur_qos;
    cur_retain_next = cur_retain;
    cur_id_next     = cur_id;
    next_id_next    = next_id;
    tries_next      = tries;
    wait_timer_next = wait_timer;
    res_valid       = 1'b0;
    res_item.action     = mqpub_pkg::ACT_PUBLISH;
    res_item.message_id = cur_id;
    res_item.qos        = cur_qos;
    res_item.retain     = cur_retain;
    res_item.dup        = 1'b0;

    case (item.opcode)
      mqpub_pkg::OP_PUBLISH: begin
        res_valid = 1'b1;
        if (busy) begin
          res_item.action     = mqpub_pkg::ACT_BUSY;
          res_item.message_id = 16'd0;
          res_item.qos        = rq;
          res_item.retain     = item.request_retain;
        end else begin
          // Take a fresh id; the counter skips zero on wrap
          cur_id_next     = next_id;
          next_id_next    = (next_id == 16'hFFFF) ? 16'd1 : next_id + 16'd1;
          cur_qos_next    = rq;
          cur_retain_next = item.request_retain;
          state_next      = mqpub_pkg::ST_WAIT_ACK;
          tries_next      = 4'd0;
          wait_timer_next = cfg.reply_wait_ticks;
          res_item.message_id = next_id;
          res_item.qos        = rq;
          res_item.retain     = item.request_retain;
        end
      end
      mqpub_pkg::OP_ACK: begin
        if (busy && item.ack_message_id == cur_id) begin
          case (state)
            mqpub_pkg::ST_WAIT_ACK: begin
              if (cur_qos == mqpub_pkg::QOS_1 && item.ack_kind == mqpub_pkg::ACK_PUBACK) begin
                res_valid       = 1'b1;
                res_item.action = mqpub_pkg::ACT_DONE_OK;
                state_next      = mqpub_pkg::ST_IDLE;
                tries_next      = 4'd0;
                wait_timer_next = 16'd0;
              end else if (cur_qos == mqpub_pkg::QOS_2 &&
                           item.ack_kind == mqpub_pkg::ACK_PUBREC) begin
                res_valid       = 1'b1;
                res_item.action = mqpub_pkg::ACT_PUBREL;
                state_next      = mqpub_pkg::ST_WAIT_COMP;
                tries_next      = 4'd0;
                wait_timer_next = cfg.reply_wait_ticks;
              end
            end
            mqpub_pkg::ST_WAIT_COMP: begin
              if (item.ack_kind == mqpub_pkg::ACK_PUBCOMP) begin
                res_valid       = 1'b1;
                res_item.action = mqpub_pkg::ACT_DONE_OK;
                state_next      = mqpub_pkg::ST_IDLE;
                tries_next      = 4'd0;
                wait_timer_next = 16'd0;
              end
            end
            default: begin
            end
          endcase
        end
      end
      mqpub_pkg::OP_TICK: begin
        if (busy) begin
          if (wait_timer > 16'd1) begin
            wait_timer_next = wait_timer - 16'd1;
          end else if (tries_inc >= cfg.max_tries) begin
            res_valid = 1'b1;
            if (state == mqpub_pkg::ST_WAIT_ACK) begin
              // Give up the exchange
              res_item.action = mqpub_pkg::ACT_DONE_FAIL;
              state_next      = mqpub_pkg::ST_IDLE;
              tries_next      = 4'd0;
              wait_timer_next = 16'd0;
            end else begin
              // Restart from PUBLISH, not flagged as a duplicate
              res_item.action = mqpub_pkg::ACT_PUBLISH;
              state_next      = mqpub_pkg::ST_WAIT_ACK;
              tries_next      = 4'd0;
              wait_timer_next = cfg.reply_wait_ticks;
            end
          end else begin
            res_valid       = 1'b1;
            tries_next      = tries_inc;
            wait_timer_next = cfg.reply_wait_ticks;
            if (state == mqpub_pkg::ST_WAIT_ACK) begin
              res_item.action = mqpub_pkg::ACT_PUBLISH;
              res_item.dup    = 1'b1;
            end else begin
              res_item.action = mqpub_pkg::ACT_PUBREL;
            end
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= mqpub_pkg::ST_IDLE;
      cur_qos    <= mqpub_pkg::QOS_1;
      cur_retain <= 1'b0;
      cur_id     <= 16'd0;
      next_id    <= 16'd1;
      tries      <= 4'd0;
      wait_timer <= 16'd0;
    end else if (step) begin
      state      <= state_next;
      cur_qos    <= cur_qos_next;
      cur_retain <= cur_retain_next;
      cur_id     <= cur_id_next;
      next_id    <= next_id_next;
      tries      <= tries_next;
      wait_timer <= wait_timer_next;
    end
  end

endmodule

[src/mqpub_out_stage.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mqpub_out_stage
// Result register: holds a result until the downstream side takes it.
// ----------------------------------------------------------------------------
module mqpub_out_stage (
  input  logic                clk,
  input  logic                rst,
  input  logic                load,
  input  logic                res_valid,
  input  mqpub_pkg::out_item_t res_item,
  output logic                advance,
  output logic                out_valid,
  input  logic                out_stall,
  output mqpub_pkg::out_item_t out_data
);

  assign advance = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= load && res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && load && res_valid) begin
      out_data <= res_item;
    end
  end

endmodule
